>>> hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LFS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lfs same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define LFS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lfs next-cycle check failed");

`endif

>>> hdl/lfs_pkg.sv
// types, codes and helper functions of the line follow steering block
package lfs_pkg;

    localparam int SENSOR_BITS = 12;
    localparam int SPEED_BITS  = 9;
    localparam int DIFF_BITS   = 10;
    localparam int NUM_LANES   = 4;
    localparam logic [SPEED_BITS-1:0] SPEED_LIMIT = 9'd300;

    // register reset values
    localparam logic [SPEED_BITS-1:0]  BASE_SPEED_RST = 9'd30;
    localparam logic [SENSOR_BITS-1:0] BLACK_ON_RST   = 12'd1000;
    localparam logic [SENSOR_BITS-1:0] WHITE_OFF_RST  = 12'd500;

    // register indexes on the config port
    localparam logic [1:0] CFG_BASE_SPEED = 2'd0;
    localparam logic [1:0] CFG_BLACK_ON   = 2'd1;
    localparam logic [1:0] CFG_WHITE_OFF  = 2'd2;

    // reciprocal of 6 in 12 fractional bits, exact for inputs below 2048
    localparam logic [9:0] DIV6_MUL = 10'd683;

    // special line patterns
    localparam logic [3:0] PAT_CENTER    = 4'h6;
    localparam logic [3:0] PAT_ALL_BLACK = 4'hF;
    localparam logic [3:0] PAT_ALL_WHITE = 4'h0;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_START  = 2'd1,
        MODE_STOP   = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CMD_NONE    = 2'd0,
        CMD_TARGETS = 2'd1,
        CMD_STOP    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_LOST    = 2'd0,
        ST_TRACK   = 2'd1,
        ST_RECOVER = 2'd2,
        ST_BLACK   = 2'd3
    } run_state_t;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_RIGHT = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        SGN_ZERO = 2'd0,
        SGN_NEG  = 2'd1,
        SGN_POS  = 2'd2
    } sgn_t;

    typedef enum logic [1:0] {
        ACT_STRAIGHT = 2'd0,
        ACT_HALT     = 2'd1,
        ACT_TURN     = 2'd2
    } act_t;

    // turn level index: 0 is level 1 (mildest) .. 3 is level 4 (slow wheel stopped)
    typedef enum logic [1:0] {
        LVL_1 = 2'd0,
        LVL_2 = 2'd1,
        LVL_3 = 2'd2,
        LVL_4 = 2'd3
    } level_t;

    typedef struct packed {
        cmd_t                         drive_command;
        logic [SPEED_BITS-1:0]        left_target;
        logic [SPEED_BITS-1:0]        right_target;
        run_state_t                   run_state;
        logic [NUM_LANES-1:0]         line_pattern;
        logic signed [DIFF_BITS-1:0]  steer_difference;
    } result_t;

    // floor(x / 6) for x below 2048
    function automatic logic [SPEED_BITS-1:0] div6(input logic [10:0] x);
        logic [21:0] prod;
        prod = 22'(x) * 22'(DIV6_MUL);
        return SPEED_BITS'(prod >> 12);
    endfunction

endpackage

>>> hdl/lfs_lane.sv
// one sensor lane: on/off hysteresis of a single sensor bit
module lfs_lane (
    input  logic [lfs_pkg::SENSOR_BITS-1:0] sample,
    input  logic [lfs_pkg::SENSOR_BITS-1:0] black_on_level,
    input  logic [lfs_pkg::SENSOR_BITS-1:0] white_off_level,
    input  logic                            bit_cur,
    output logic                            bit_new
);

    // setting wins when both levels are met
    always_comb begin
        if (sample >= black_on_level) begin
            bit_new = 1'b1;
        end else if (sample <= white_off_level) begin
            bit_new = 1'b0;
        end else begin
            bit_new = bit_cur;
        end
    end

endmodule

>>> hdl/lfs_steer.sv
// merge stage: pattern decode, wheel targets and tracking state
module lfs_steer (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 req_accept,
    input  lfs_pkg::mode_t                       req_mode,
    input  logic                                 req_sample_valid,
    input  logic [lfs_pkg::NUM_LANES-1:0]        lane_bits,
    input  logic [lfs_pkg::SPEED_BITS-1:0]       base_speed,
    output logic [lfs_pkg::NUM_LANES-1:0]        sensor_bits,
    output lfs_pkg::result_t                     result
);

    logic                                following_reg, following_next;
    lfs_pkg::run_state_t                 run_reg, run_next;
    logic [lfs_pkg::NUM_LANES-1:0]       bits_reg, bits_next;
    lfs_pkg::dir_t                       lock_reg, lock_next;
    lfs_pkg::sgn_t                       sign_reg, sign_next;
    logic signed [lfs_pkg::DIFF_BITS-1:0] diff_reg, diff_next;

    logic [lfs_pkg::SPEED_BITS-1:0]      base_clamp;
    logic [lfs_pkg::SPEED_BITS-1:0]      slow_l1, slow_l2, slow_l3, slow_sel;
    lfs_pkg::act_t                       act;
    lfs_pkg::dir_t                       turn_dir, fallback;
    lfs_pkg::level_t                     turn_lvl;
    logic                                recover;
    logic signed [lfs_pkg::DIFF_BITS-1:0] turn_gap;
    logic                                tick_live;

    assign sensor_bits = bits_reg;
    assign tick_live   = (req_mode == lfs_pkg::MODE_TICK) && following_reg;

    // wheel speeds: fast wheel is the clamped base, slow wheel round(base*r/30)
    always_comb begin
        base_clamp = (base_speed > lfs_pkg::SPEED_LIMIT) ? lfs_pkg::SPEED_LIMIT : base_speed;
        slow_l1    = lfs_pkg::div6(11'(base_clamp) * 11'd5 + 11'd3);
        slow_l2    = lfs_pkg::SPEED_BITS'((10'(base_clamp) + 10'd1) >> 1);
        slow_l3    = lfs_pkg::div6(11'(base_clamp) * 11'd2 + 11'd3);
        unique case (turn_lvl)
            lfs_pkg::LVL_1: slow_sel = slow_l1;
            lfs_pkg::LVL_2: slow_sel = slow_l2;
            lfs_pkg::LVL_3: slow_sel = slow_l3;
            lfs_pkg::LVL_4: slow_sel = '0;
            default:        slow_sel = '0;
        endcase
        turn_gap = lfs_pkg::DIFF_BITS'(base_clamp) - lfs_pkg::DIFF_BITS'(slow_sel);
    end

    // fallback direction: lock, else last error sign, else right
    always_comb begin
        if (lock_reg == lfs_pkg::DIR_LEFT || lock_reg == lfs_pkg::DIR_RIGHT) begin
            fallback = lock_reg;
        end else if (sign_reg == lfs_pkg::SGN_NEG) begin
            fallback = lfs_pkg::DIR_LEFT;
        end else begin
            fallback = lfs_pkg::DIR_RIGHT;
        end
    end

    // pattern decode from the merged lane bits
    always_comb begin
        act      = lfs_pkg::ACT_TURN;
        turn_dir = fallback;
        turn_lvl = lfs_pkg::LVL_3;
        recover  = 1'b0;
        unique case (lane_bits)
            lfs_pkg::PAT_CENTER:    act = lfs_pkg::ACT_STRAIGHT;
            lfs_pkg::PAT_ALL_BLACK: act = lfs_pkg::ACT_HALT;
            lfs_pkg::PAT_ALL_WHITE: begin
                turn_lvl = lfs_pkg::LVL_4;
                recover  = 1'b1;
            end
            4'hE: begin turn_dir = lfs_pkg::DIR_LEFT;  turn_lvl = lfs_pkg::LVL_1; end
            4'h7: begin turn_dir = lfs_pkg::DIR_RIGHT; turn_lvl = lfs_pkg::LVL_1; end
            4'h4: begin turn_dir = lfs_pkg::DIR_LEFT;  turn_lvl = lfs_pkg::LVL_2; end
            4'h2: begin turn_dir = lfs_pkg::DIR_RIGHT; turn_lvl = lfs_pkg::LVL_2; end
            4'hC: begin turn_dir = lfs_pkg::DIR_LEFT;  turn_lvl = lfs_pkg::LVL_3; end
            4'h3: begin turn_dir = lfs_pkg::DIR_RIGHT; turn_lvl = lfs_pkg::LVL_3; end
            4'h8: begin turn_dir = lfs_pkg::DIR_LEFT;  turn_lvl = lfs_pkg::LVL_4; end
            4'h1: begin turn_dir = lfs_pkg::DIR_RIGHT; turn_lvl = lfs_pkg::LVL_4; end
            // conflicting patterns keep the fallback direction at level 3
            default: ;
        endcase
    end

    // next state
    always_comb begin
        following_next = following_reg;
        run_next       = run_reg;
        bits_next      = bits_reg;
        lock_next      = lock_reg;
        sign_next      = sign_reg;
        diff_next      = diff_reg;
        if (req_accept) begin
            unique case (req_mode)
                lfs_pkg::MODE_START, lfs_pkg::MODE_STOP: begin
                    following_next = (req_mode == lfs_pkg::MODE_START);
                    run_next  = (req_mode == lfs_pkg::MODE_START) ? lfs_pkg::ST_TRACK
                                                                  : lfs_pkg::ST_LOST;
                    bits_next = '0;
                    lock_next = lfs_pkg::DIR_NONE;
                    sign_next = lfs_pkg::SGN_ZERO;
                    diff_next = '0;
                end
                lfs_pkg::MODE_TICK: begin
                    if (following_reg && !req_sample_valid) begin
                        run_next  = lfs_pkg::ST_LOST;
                        bits_next = '0;
                        lock_next = lfs_pkg::DIR_NONE;
                        sign_next = lfs_pkg::SGN_ZERO;
                        diff_next = '0;
                    end else if (following_reg) begin
                        bits_next = lane_bits;
                        unique case (act)
                            lfs_pkg::ACT_STRAIGHT, lfs_pkg::ACT_HALT: begin
                                run_next  = (act == lfs_pkg::ACT_HALT) ? lfs_pkg::ST_BLACK
                                                                       : lfs_pkg::ST_TRACK;
                                lock_next = lfs_pkg::DIR_NONE;
                                sign_next = lfs_pkg::SGN_ZERO;
                                diff_next = '0;
                            end
                            lfs_pkg::ACT_TURN: begin
                                run_next  = recover ? lfs_pkg::ST_RECOVER : lfs_pkg::ST_TRACK;
                                lock_next = turn_dir;
                                if (turn_dir == lfs_pkg::DIR_LEFT) begin
                                    sign_next = lfs_pkg::SGN_NEG;
                                    diff_next = -turn_gap;
                                end else begin
                                    sign_next = lfs_pkg::SGN_POS;
                                    diff_next = turn_gap;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                lfs_pkg::MODE_UNUSED: ;
                default: ;
            endcase
        end
    end

    // result fields
    always_comb begin
        result.drive_command    = lfs_pkg::CMD_NONE;
        result.left_target      = '0;
        result.right_target     = '0;
        result.run_state        = run_next;
        result.line_pattern     = bits_next;
        result.steer_difference = diff_next;
        if (req_mode == lfs_pkg::MODE_STOP) begin
            result.drive_command = lfs_pkg::CMD_STOP;
        end else if (tick_live) begin
            result.drive_command = lfs_pkg::CMD_TARGETS;
            if (req_sample_valid) begin
                unique case (act)
                    lfs_pkg::ACT_STRAIGHT: begin
                        result.left_target  = base_clamp;
                        result.right_target = base_clamp;
                    end
                    lfs_pkg::ACT_HALT: ;
                    lfs_pkg::ACT_TURN: begin
                        if (turn_dir == lfs_pkg::DIR_LEFT) begin
                            result.left_target  = slow_sel;
                            result.right_target = base_clamp;
                        end else begin
                            result.left_target  = base_clamp;
                            result.right_target = slow_sel;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            following_reg <= 1'b0;
            run_reg       <= lfs_pkg::ST_LOST;
            bits_reg      <= '0;
            lock_reg      <= lfs_pkg::DIR_NONE;
            sign_reg      <= lfs_pkg::SGN_ZERO;
            diff_reg      <= '0;
        end else begin
            following_reg <= following_next;
            run_reg       <= run_next;
            bits_reg      <= bits_next;
            lock_reg      <= lock_next;
            sign_reg      <= sign_next;
            diff_reg      <= diff_next;
        end
    end

endmodule

>>> hdl/line_follow_steering_fsm.sv
// top level of the line follow steering block: lanes, merge stage, output skid
// a result is registered in the output register, or in the skid entry while the output stalls
// throughput: one request per cycle while s_tready is high; each request sees the tracking state left by the one before
// the output register plus one skid entry keep input open while a result waits
// reset (aresetn low, synchronous): not following, lost, all tracking state clear,
// registers back to base 30, black on 1000, white off 500, output empty
module line_follow_steering_fsm (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // sense_far_left, sense_inner_left, sense_inner_right,
                                  // sense_far_right (12 bits each, lowest first)
    input  logic [2:0]  s_tuser,  // mode [1:0], sample_valid [2]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // left_target [8:0], right_target [17:9], run_state [19:18],
                                  // line_pattern [23:20], steer_difference [33:24], zero pad
    output logic [1:0]  m_tuser   // drive_command
);

    localparam int SB = lfs_pkg::SENSOR_BITS;
    localparam int NL = lfs_pkg::NUM_LANES;

    logic [lfs_pkg::SPEED_BITS-1:0] base_speed_reg;
    logic [SB-1:0]                  black_on_reg;
    logic [SB-1:0]                  white_off_reg;

    logic                           req_accept;
    logic [NL-1:0]                  sensor_bits;
    logic [NL-1:0]                  lane_bits;
    lfs_pkg::result_t               result;

    lfs_pkg::result_t               out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;
    lfs_pkg::result_t               skid_reg, skid_next;
    logic                           skid_valid_reg, skid_valid_next;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_speed_reg <= lfs_pkg::BASE_SPEED_RST;
            black_on_reg   <= lfs_pkg::BLACK_ON_RST;
            white_off_reg  <= lfs_pkg::WHITE_OFF_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lfs_pkg::CFG_BASE_SPEED: base_speed_reg <= cfg_data[lfs_pkg::SPEED_BITS-1:0];
                lfs_pkg::CFG_BLACK_ON:   black_on_reg   <= cfg_data[SB-1:0];
                lfs_pkg::CFG_WHITE_OFF:  white_off_reg  <= cfg_data[SB-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready   = !skid_valid_reg;
    assign req_accept = s_tvalid && s_tready;

    // one hysteresis lane per sensor; far left lands on the top pattern bit
    for (genvar i = 0; i < NL; i++) begin : g_lane
        lfs_lane u_lane (
            .sample          (s_tdata[i*SB +: SB]),
            .black_on_level  (black_on_reg),
            .white_off_level (white_off_reg),
            .bit_cur         (sensor_bits[NL-1-i]),
            .bit_new         (lane_bits[NL-1-i])
        );
    end

    lfs_steer u_steer (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .req_accept       (req_accept),
        .req_mode         (lfs_pkg::mode_t'(s_tuser[1:0])),
        .req_sample_valid (s_tuser[2]),
        .lane_bits        (lane_bits),
        .base_speed       (base_speed_reg),
        .sensor_bits      (sensor_bits),
        .result           (result)
    );

    // output register with one skid entry
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = result;
                out_valid_next = req_accept;
            end
        end else if (req_accept) begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // result channel packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.drive_command;
    assign m_tdata  = {6'd0,
                       out_reg.steer_difference,
                       out_reg.line_pattern,
                       out_reg.run_state,
                       out_reg.right_target,
                       out_reg.left_target};

endmodule

>>> hdl/lfs_checker.sv
// port-level checks of the line follow steering block, bound to the top level
`include "assert_macros.svh"

module lfs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result holds
    `LFS_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // two results waiting fill output and skid, so input closes
    `LFS_ASSERT_NXT(a_full, aclk, aresetn, m_tvalid && !m_tready && s_tvalid && s_tready && !$past(s_tvalid && s_tready && m_tvalid && !m_tready) && $past(m_tvalid && !m_tready), !s_tready)

    // a stop clears every tracking field and both targets
    `LFS_ASSERT_IMP(a_stop_clear, aclk, aresetn, m_tvalid && m_tuser == lfs_pkg::CMD_STOP, m_tdata[33:0] == 34'd0)

    // the all-black stop sets both targets to zero with a full pattern
    `LFS_ASSERT_IMP(a_black_halt, aclk, aresetn, m_tvalid && m_tuser == lfs_pkg::CMD_TARGETS && m_tdata[19:18] == lfs_pkg::ST_BLACK, m_tdata[17:0] == 18'd0 && m_tdata[23:20] == lfs_pkg::PAT_ALL_BLACK && m_tdata[33:24] == 10'd0)

endmodule

bind line_follow_steering_fsm lfs_checker u_lfs_checker (.*);

>>> sim/tb.sv
// self-checking testbench for the line follow steering block
`timescale 1ns / 1ps

module tb;
    import lfs_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_CYCLES = 4;

    // one-sided line patterns, far left is bit 3
    localparam logic [3:0] PAT_LEFT_1  = 4'hE;
    localparam logic [3:0] PAT_RIGHT_1 = 4'h7;
    localparam logic [3:0] PAT_LEFT_2  = 4'h4;
    localparam logic [3:0] PAT_RIGHT_2 = 4'h2;
    localparam logic [3:0] PAT_LEFT_3  = 4'hC;
    localparam logic [3:0] PAT_RIGHT_3 = 4'h3;
    localparam logic [3:0] PAT_LEFT_4  = 4'h8;
    localparam logic [3:0] PAT_RIGHT_4 = 4'h1;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [11:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;  // sense_far_left, sense_inner_left, sense_inner_right,
                                  // sense_far_right (12 bits each, lowest first)
    logic [2:0]  s_tuser   = '0;  // mode [1:0], sample_valid [2]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;         // left_target, right_target, run_state, line_pattern,
                                  // steer_difference, zero pad
    logic [1:0]  m_tuser;         // drive_command

    // register shadows
    logic [8:0]  cfg_base_q  = BASE_SPEED_RST;
    logic [11:0] cfg_black_q = BLACK_ON_RST;
    logic [11:0] cfg_white_q = WHITE_OFF_RST;

    // tracking state of the steering predictor
    logic              trk_following = 1'b0;
    run_state_t        trk_state     = ST_LOST;
    logic [3:0]        trk_bits      = '0;
    dir_t              trk_lock      = DIR_NONE;
    sgn_t              trk_sign      = SGN_ZERO;
    logic signed [9:0] trk_diff      = '0;
    cmd_t              nxt_cmd;
    logic [8:0]        nxt_left;
    logic [8:0]        nxt_right;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      cycle_count    = 0;
    logic    sender_gaps    = 1'b1;
    logic    recv_stalls    = 1'b1;
    logic    hold_off       = 1'b0;
    int      stall_left     = 0;
    event    start_hold;

    line_follow_steering_fsm u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------- steering predictor ----------------

    function automatic logic [8:0] scaled_speed(int base, int ratio);
        int v;
        v = (base * ratio + 15) / 30;
        if (v > int'(SPEED_LIMIT)) v = int'(SPEED_LIMIT);
        return v[8:0];
    endfunction

    function automatic int clamped_base();
        return (cfg_base_q > SPEED_LIMIT) ? int'(SPEED_LIMIT) : int'(cfg_base_q);
    endfunction

    function automatic void clear_tracking();
        trk_bits = '0;
        trk_lock = DIR_NONE;
        trk_sign = SGN_ZERO;
        trk_diff = '0;
    endfunction

    // locked direction, else sign of the last error, else right
    function automatic dir_t fallback_dir();
        if (trk_lock == DIR_LEFT || trk_lock == DIR_RIGHT) return trk_lock;
        if (trk_sign == SGN_NEG) return DIR_LEFT;
        return DIR_RIGHT;
    endfunction

    function automatic void steer_turn(dir_t d, level_t lv);
        int ratio;
        logic [8:0] fast;
        logic [8:0] slow;
        case (lv)
            LVL_1:   ratio = 25;
            LVL_2:   ratio = 15;
            LVL_3:   ratio = 10;
            default: ratio = 0;
        endcase
        fast = scaled_speed(clamped_base(), 30);
        slow = scaled_speed(clamped_base(), ratio);
        trk_state = ST_TRACK;
        nxt_cmd   = CMD_TARGETS;
        if (d == DIR_LEFT) begin
            trk_lock  = DIR_LEFT;
            trk_sign  = SGN_NEG;
            trk_diff  = 10'($signed({1'b0, slow}) - $signed({1'b0, fast}));
            nxt_left  = slow;
            nxt_right = fast;
        end else begin
            trk_lock  = DIR_RIGHT;
            trk_sign  = SGN_POS;
            trk_diff  = 10'($signed({1'b0, fast}) - $signed({1'b0, slow}));
            nxt_left  = fast;
            nxt_right = slow;
        end
    endfunction

    function automatic void apply_line_pattern();
        case (trk_bits)
            PAT_CENTER: begin
                trk_state = ST_TRACK;
                trk_lock  = DIR_NONE;
                trk_sign  = SGN_ZERO;
                trk_diff  = '0;
                nxt_cmd   = CMD_TARGETS;
                nxt_left  = 9'(clamped_base());
                nxt_right = 9'(clamped_base());
            end
            PAT_ALL_BLACK: begin
                trk_state = ST_BLACK;
                trk_lock  = DIR_NONE;
                trk_sign  = SGN_ZERO;
                trk_diff  = '0;
                nxt_cmd   = CMD_TARGETS;
            end
            PAT_ALL_WHITE: begin
                steer_turn(fallback_dir(), LVL_4);
                trk_state = ST_RECOVER;
            end
            PAT_LEFT_1:  steer_turn(DIR_LEFT, LVL_1);
            PAT_RIGHT_1: steer_turn(DIR_RIGHT, LVL_1);
            PAT_LEFT_2:  steer_turn(DIR_LEFT, LVL_2);
            PAT_RIGHT_2: steer_turn(DIR_RIGHT, LVL_2);
            PAT_LEFT_3:  steer_turn(DIR_LEFT, LVL_3);
            PAT_RIGHT_3: steer_turn(DIR_RIGHT, LVL_3);
            PAT_LEFT_4:  steer_turn(DIR_LEFT, LVL_4);
            PAT_RIGHT_4: steer_turn(DIR_RIGHT, LVL_4);
            // conflicting patterns
            default:     steer_turn(fallback_dir(), LVL_3);
        endcase
    endfunction

    function automatic result_t predict_steering(mode_t md, logic ok, logic [47:0] smp);
        result_t    r;
        logic [11:0] s;
        nxt_cmd   = CMD_NONE;
        nxt_left  = '0;
        nxt_right = '0;
        case (md)
            MODE_START: begin
                trk_following = 1'b1;
                trk_state     = ST_TRACK;
                clear_tracking();
            end
            MODE_STOP: begin
                trk_following = 1'b0;
                trk_state     = ST_LOST;
                clear_tracking();
                nxt_cmd       = CMD_STOP;
            end
            MODE_TICK: begin
                if (trk_following && !ok) begin
                    // failed read zeroes both wheels
                    trk_state = ST_LOST;
                    clear_tracking();
                    nxt_cmd   = CMD_TARGETS;
                end else if (trk_following) begin
                    // hysteresis per sensor, setting wins on overlap
                    for (int i = 0; i < 4; i++) begin
                        s = smp[12*i +: 12];
                        if (s >= cfg_black_q) trk_bits[3-i] = 1'b1;
                        else if (s <= cfg_white_q) trk_bits[3-i] = 1'b0;
                    end
                    apply_line_pattern();
                end
            end
            default: ;
        endcase
        r.drive_command    = nxt_cmd;
        r.left_target      = nxt_left;
        r.right_target     = nxt_right;
        r.run_state        = trk_state;
        r.line_pattern     = trk_bits;
        r.steer_difference = trk_diff;
        return r;
    endfunction

    // ---------------- result side ----------------

    task automatic report_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                mismatch_count++;
            end else begin
                exp_r = pending_results.pop_front();
                report_field("drive_command", int'(exp_r.drive_command), int'(m_tuser));
                report_field("left_target", int'(exp_r.left_target), int'(m_tdata[8:0]));
                report_field("right_target", int'(exp_r.right_target), int'(m_tdata[17:9]));
                report_field("run_state", int'(exp_r.run_state), int'(m_tdata[19:18]));
                report_field("line_pattern", int'(exp_r.line_pattern), int'(m_tdata[23:20]));
                report_field("steer_difference", int'(exp_r.steer_difference),
                             int'($signed(m_tdata[33:24])));
            end
        end
    end

    // receiver readiness with random stalls and the long hold-off
    always @(posedge aclk) begin
        if (hold_off) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (recv_stalls && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            m_tready <= (stall_left == 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // long hold-off counted here
    always begin
        @(start_hold);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // ---------------- request side ----------------

    task automatic send_request(mode_t md, logic ok, logic [47:0] smp);
        int gap;
        gap = sender_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= {ok, md};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_steering(md, ok, smp));
    endtask

    task automatic sensor_tick(logic [11:0] fl, logic [11:0] il, logic [11:0] ir,
                               logic [11:0] fr);
        send_request(MODE_TICK, 1'b1, {fr, ir, il, fl});
    endtask

    // pause the sender until every result is back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_registers(logic [8:0] base, logic [11:0] black,
                                     logic [11:0] white);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BASE_SPEED;
        cfg_data  <= 12'(base);
        @(posedge aclk);
        cfg_index <= CFG_BLACK_ON;
        cfg_data  <= black;
        @(posedge aclk);
        cfg_index <= CFG_WHITE_OFF;
        cfg_data  <= white;
        @(posedge aclk);
        cfg_we      <= 1'b0;
        cfg_base_q  = base;
        cfg_black_q = black;
        cfg_white_q = white;
    endtask

    // sample biased toward the white, black and hold bands of the current thresholds
    function automatic logic [11:0] random_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 12'($urandom_range(0, cfg_white_q));
        if (r < 8) return 12'($urandom_range(cfg_black_q, 4095));
        if (r == 8 && cfg_black_q > cfg_white_q + 1)
            return 12'($urandom_range(cfg_white_q + 1, cfg_black_q - 1));
        return 12'($urandom_range(0, 4095));
    endfunction

    task automatic send_random_request();
        int          pick;
        logic [47:0] smp;
        pick = $urandom_range(0, 99);
        smp  = {random_sample(), random_sample(), random_sample(), random_sample()};
        if (pick < 87) send_request(MODE_TICK, 1'b1, smp);
        else if (pick < 92) send_request(MODE_TICK, 1'b0, smp);
        else if (pick < 95) send_request(MODE_START, 1'($urandom_range(0, 1)), smp);
        else if (pick < 97) send_request(MODE_STOP, 1'($urandom_range(0, 1)), smp);
        else send_request(MODE_UNUSED, 1'($urandom_range(0, 1)), smp);
    endtask

    // start following, then random traffic in stretches with and without idling
    task automatic run_random_traffic(int count);
        send_request(MODE_START, 1'b1, '0);
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0) begin
                sender_gaps = ($urandom_range(0, 3) != 0);
                recv_stalls <= ($urandom_range(0, 3) != 0);
            end
            send_random_request();
        end
        wait_for_results();
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_cases();
        send_request(MODE_TICK, 1'b1, '1);          // not following yet
        send_request(MODE_UNUSED, 1'b1, '1);        // unused mode
        send_request(MODE_START, 1'b0, '0);
        sensor_tick(12'd0, 12'd4095, 12'd4095, 12'd0);        // centered
        sensor_tick(12'd4095, 12'd4095, 12'd4095, 12'd4095);  // all black
        sensor_tick(12'd0, 12'd0, 12'd0, 12'd0);              // all white, default right
        sensor_tick(12'd1000, 12'd1000, 12'd1000, 12'd500);   // left level 1
        sensor_tick(12'd0, 12'd0, 12'd0, 12'd0);              // all white, locked left
        sensor_tick(12'd0, 12'd1000, 12'd1000, 12'd1000);     // right level 1
        sensor_tick(12'd0, 12'd750, 12'd500, 12'd0);          // hold band keeps inner left
        sensor_tick(12'd0, 12'd0, 12'd4095, 12'd0);           // right level 2
        sensor_tick(12'd4095, 12'd4095, 12'd0, 12'd0);        // left level 3
        sensor_tick(12'd0, 12'd0, 12'd4095, 12'd4095);        // right level 3
        sensor_tick(12'd4095, 12'd0, 12'd0, 12'd0);           // left level 4
        sensor_tick(12'd0, 12'd0, 12'd0, 12'd4095);           // right level 4
        sensor_tick(12'd4095, 12'd0, 12'd4095, 12'd0);        // conflicting, locked right
        sensor_tick(12'd4095, 12'd4095, 12'd0, 12'd4095);     // conflicting
        send_request(MODE_TICK, 1'b0, '1);                    // failed read
        sensor_tick(12'd0, 12'd4095, 12'd0, 12'd4095);        // conflicting, no lock
        send_request(MODE_STOP, 1'b1, '0);
        sensor_tick(12'd4095, 12'd0, 12'd0, 12'd0);           // ignored after stop
        wait_for_results();
    endtask

    task automatic run_phase(logic [8:0] base, logic [11:0] black, logic [11:0] white,
                             int count);
        program_registers(base, black, white);
        run_random_traffic(count);
    endtask

    task automatic test_threshold_settings();
        logic [11:0] w;
        run_random_traffic(120);                        // reset values
        run_phase(9'd0, 12'd1000, 12'd500, 200);
        run_phase(9'd300, 12'd4095, 12'd0, 200);
        run_phase(9'd511, 12'd0, 12'd4095, 100);        // overlap everywhere, base clamped
        run_phase(9'd301, 12'd2000, 12'd3000, 200);     // partial overlap
        run_phase(9'd1, 12'd2048, 12'd2047, 200);       // no hold band
        for (int k = 0; k < 4; k++) begin
            w = 12'($urandom_range(0, 3800));
            run_phase(9'($urandom_range(0, 511)), w + 12'($urandom_range(1, 290)), w, 200);
        end
        program_registers(BASE_SPEED_RST, BLACK_ON_RST, WHITE_OFF_RST);
    endtask

    // receiver holds off while the sender streams back to back
    task automatic test_output_backpressure();
        sender_gaps = 1'b0;
        send_request(MODE_START, 1'b1, '0);
        -> start_hold;
        for (int n = 0; n < 30; n++) send_random_request();
        wait_for_results();
        sender_gaps = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_threshold_settings();
        test_output_backpressure();
        wait_for_results();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
